### rtl/core/binary_multiset_rank_unrank_top_assert.svh
// Assertion macros for the binary multiset rank and unrank block.
`ifndef BINARY_MULTISET_RANK_UNRANK_TOP_ASSERT_SVH
`define BINARY_MULTISET_RANK_UNRANK_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define BMRU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bmru check failed");

// Check that a condition in a cycle implies another in the next cycle.
`define BMRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmru check failed");

`endif

### rtl/core/bmru_pkg.sv
// Shared types, constants and helpers of the binary multiset rank and unrank block.
`default_nettype none

package bmru_pkg;

  // Longest sequence and binomial table geometry
  localparam int unsigned MAX_LEN   = 64;
  localparam int unsigned TSIDE     = MAX_LEN + 1;
  localparam int unsigned TBL_DEPTH = TSIDE * TSIDE;
  localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);
  localparam int unsigned LEN_W     = $clog2(TSIDE);

  // Field widths
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SUM_W      = CNT_W + 1;
  localparam int unsigned RANK_W     = 64;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    MODE_RANK = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_NEXT = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_COUNT = 4'd0,
    CFG_ONE_COUNT  = 4'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BLD_RUN,
    BLD_FLUSH,
    BLD_READY
  } build_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic              elem_bit;
    logic [RANK_W-1:0] rank_in;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_out;
    logic              bit_out;
    logic              done_res;
    logic              error;
  } res_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  // Flat table address of C(n,k)
  function automatic addr_t tbl_addr(input addr_t n, input addr_t k);
    return n * addr_t'(TSIDE) + k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/binary_multiset_rank_unrank_top.sv
// Top level of the binary multiset rank and unrank block.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (mode, elem_bit, rank_in)
//   out      output     out_valid_o / out_ready_i out_data_o (rank_out, bit_out, done_res, error)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The binomial table read of each request is addressed by the counts the previous
// request left, and the table memory returns data through a registered read.
// After reset the table is built by Pascal recurrence; in_ready_o stays low meanwhile,
// and cfg writes are taken. No new request is taken while a table read is in flight.
// Results go to a two-entry queue, so a new request is taken while one result waits.
// cfg_ready_o is always high.
`default_nettype none

module binary_multiset_rank_unrank_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire bmru_pkg::item_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output bmru_pkg::res_t                       out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bmru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bmru_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmru_pkg::*;

  rd_req_t           rd_req;
  logic [RANK_W-1:0] rdata;
  logic              tbl_ready;
  logic              room, push;
  res_t              push_data;

  assign cfg_ready_o = 1'b1;

  // Binomial table and its build sequencer
  bmru_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eng_req_i (rd_req),
    .rdata_o   (rdata),
    .ready_o   (tbl_ready)
  );

  // Sequence state and per-request update
  bmru_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tbl_ready_i (tbl_ready),
    .rd_req_o    (rd_req),
    .rdata_i     (rdata),
    .room_i      (room),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Result queue
  bmru_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/core/bmru_table.sv
// Binomial table memory with its Pascal recurrence build sequencer.
`default_nettype none

module bmru_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bmru_pkg::rd_req_t         eng_req_i,
  output logic [bmru_pkg::RANK_W-1:0]    rdata_o,
  output logic                           ready_o
);
  import bmru_pkg::*;

  logic [RANK_W-1:0] mem [TBL_DEPTH];
  logic [RANK_W-1:0] rdata_q;

  build_e            state_q, state_d;
  logic [LEN_W-1:0]  bn_q, bn_d, bk_q, bk_d;
  logic              issue, bld_rd;
  logic              wv_q;
  logic [LEN_W-1:0]  wn_q, wk_q;
  logic [RANK_W-1:0] last_q;

  logic              we, ren;
  addr_t             waddr, raddr, bld_addr;
  logic [RANK_W-1:0] wdata, up_val, left_val;

  // Sweep rows and columns of the triangle, one entry a cycle
  always_comb begin
    state_d = state_q;
    bn_d    = bn_q;
    bk_d    = bk_q;
    issue   = 1'b0;
    bld_rd  = 1'b0;
    case (state_q)
      BLD_RUN: begin
        issue  = 1'b1;
        bld_rd = (bn_q != '0) && (bk_q < bn_q);
        if (bk_q == bn_q) begin
          if (bn_q == LEN_W'(MAX_LEN)) begin
            state_d = BLD_FLUSH;
          end else begin
            bn_d = bn_q + LEN_W'(1);
            bk_d = '0;
          end
        end else begin
          bk_d = bk_q + LEN_W'(1);
        end
      end
      BLD_FLUSH: begin
        state_d = BLD_READY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BLD_RUN;
      bn_q    <= '0;
      bk_q    <= '0;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bn_q    <= bn_d;
      bk_q    <= bk_d;
      wv_q    <= issue;
    end
  end

  // Hold the coordinates of the entry whose upper neighbor is being read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      wn_q <= bn_q;
      wk_q <= bk_q;
    end
    if (wv_q) begin
      last_q <= rdata_q;
    end
  end

  // C(n,k) = C(n-1,k) + C(n-1,k-1), the first row is a single one
  assign up_val   = (wk_q < wn_q) ? rdata_q : '0;
  assign left_val = (wk_q != '0) ? last_q : '0;
  assign wdata    = (wn_q == '0) ? RANK_W'(1) : up_val + left_val;
  assign we       = wv_q;
  assign waddr    = tbl_addr(addr_t'(wn_q), addr_t'(wk_q));
  assign bld_addr = tbl_addr(addr_t'(bn_q - LEN_W'(1)), addr_t'(bk_q));

  // Hand the read port to the engine once the table is built
  assign ready_o = (state_q == BLD_READY);
  assign ren     = ready_o ? eng_req_i.en : bld_rd;
  assign raddr   = ready_o ? eng_req_i.addr : bld_addr;

  // Memory with one write and one registered read, forward a same-address write
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/bmru_engine.sv
// Rank and unrank engine: sequence counters, table lookup and result update.
`default_nettype none

module bmru_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bmru_pkg::item_t               in_data_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bmru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bmru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          tbl_ready_i,
  output bmru_pkg::rd_req_t                  rd_req_o,
  input  wire logic [bmru_pkg::RANK_W-1:0]   rdata_i,
  input  wire logic                          room_i,
  output logic                               push_o,
  output bmru_pkg::res_t                     push_data_o
);
  import bmru_pkg::*;

  logic [CNT_W-1:0]  zc_q, oc_q;
  logic [CNT_W-1:0]  zl_q, zl_d, ol_q, ol_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              busy_q;
  item_t             hold_q;

  logic              accept;
  logic [SUM_W-1:0]  tot, cfg_tot, look_n;
  logic [CNT_W-1:0]  look_k;
  logic              look_ok, over, cfg_over;
  logic              bit_r, done_r, err_r;
  logic [RANK_W-1:0] binom, report;

  assign in_ready_o = tbl_ready_i && !busy_q && room_i;
  assign accept     = in_valid_i && in_ready_o;

  assign tot      = {1'b0, zl_q} + {1'b0, ol_q};
  assign cfg_tot  = {1'b0, zc_q} + {1'b0, oc_q};
  assign over     = int'(tot) > MAX_LEN;
  assign cfg_over = int'(cfg_tot) > MAX_LEN;

  // Pick the binomial the request needs and issue the table read
  always_comb begin
    if (mode_e'(in_data_i.mode) == MODE_LOAD) begin
      look_n = cfg_tot;
      look_k = zc_q;
    end else begin
      look_n = tot - SUM_W'(1);
      look_k = zl_q - CNT_W'(1);
    end
    look_ok       = (int'(look_n) <= MAX_LEN) && ({1'b0, look_k} <= look_n);
    rd_req_o.en   = accept;
    rd_req_o.addr = look_ok ? tbl_addr(addr_t'(look_n), addr_t'(look_k)) : '0;
  end

  assign binom = rdata_i;

  // Apply the request once its binomial is back
  always_comb begin
    zl_d   = zl_q;
    ol_d   = ol_q;
    rank_d = rank_q;
    bit_r  = 1'b0;
    done_r = 1'b0;
    err_r  = 1'b0;
    case (mode_e'(hold_q.mode))
      MODE_RANK: begin
        if (over) begin
          err_r = 1'b1;
        end else if (hold_q.elem_bit) begin
          if (ol_q == '0) begin
            err_r = 1'b1;
          end else begin
            if (zl_q != '0) begin
              rank_d = rank_q + binom;
            end
            ol_d = ol_q - CNT_W'(1);
          end
        end else if (zl_q == '0) begin
          err_r = 1'b1;
        end else begin
          zl_d = zl_q - CNT_W'(1);
        end
      end
      MODE_LOAD: begin
        zl_d   = zc_q;
        ol_d   = oc_q;
        rank_d = '0;
        if (cfg_over || (hold_q.rank_in >= binom)) begin
          err_r = 1'b1;
        end else begin
          rank_d = hold_q.rank_in;
        end
      end
      MODE_NEXT: begin
        if (over || ((zl_q == '0) && (ol_q == '0))) begin
          err_r = 1'b1;
        end else if (zl_q == '0) begin
          bit_r = 1'b1;
          ol_d  = ol_q - CNT_W'(1);
        end else if (binom > rank_q) begin
          zl_d = zl_q - CNT_W'(1);
        end else if (ol_q != '0) begin
          rank_d = rank_q - binom;
          bit_r  = 1'b1;
          ol_d   = ol_q - CNT_W'(1);
        end else begin
          err_r = 1'b1;
        end
      end
      default: begin
      end
    endcase
    report = rank_d;
    // Restart after a completed sequence
    if (((mode_e'(hold_q.mode) == MODE_RANK) || (mode_e'(hold_q.mode) == MODE_NEXT)) &&
        !err_r && (zl_d == '0) && (ol_d == '0)) begin
      done_r = 1'b1;
      zl_d   = zc_q;
      ol_d   = oc_q;
      rank_d = '0;
    end
  end

  assign push_o               = busy_q;
  assign push_data_o.rank_out = report;
  assign push_data_o.bit_out  = bit_r;
  assign push_data_o.done_res = done_r;
  assign push_data_o.error    = err_r;

  // Advance the sequence state, a register write restarts the sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_q   <= '0;
      oc_q   <= '0;
      zl_q   <= '0;
      ol_q   <= '0;
      rank_q <= '0;
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
      if (busy_q) begin
        zl_q   <= zl_d;
        ol_q   <= ol_d;
        rank_q <= rank_d;
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ZERO_COUNT: begin
            zc_q   <= cfg_data_i;
            zl_q   <= cfg_data_i;
            ol_q   <= oc_q;
            rank_q <= '0;
          end
          CFG_ONE_COUNT: begin
            oc_q   <= cfg_data_i;
            zl_q   <= zc_q;
            ol_q   <= cfg_data_i;
            rank_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the request payload while its table read is in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmru_out_fifo.sv
// Two-entry result queue between the engine and the output channel.
`default_nettype none

module bmru_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bmru_pkg::res_t push_data_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bmru_pkg::res_t      out_data_o
);
  import bmru_pkg::*;

  res_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign room_o      = (cnt_q != 2'd2);
  assign out_data_o  = ent_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Store an incoming result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bmru_checker.sv
// Port-level checker of the binary multiset rank and unrank block and its bind.
`default_nettype none
`include "binary_multiset_rank_unrank_top_assert.svh"

module bmru_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire bmru_pkg::res_t out_data_o
);
  import bmru_pkg::*;

  // A stalled result holds
  `BMRU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // An erroneous request emits no element and completes no sequence
  `BMRU_ASSERT(a_err_excl, clk_i, rst_ni, out_valid_o && out_data_o.error |-> !out_data_o.bit_out && !out_data_o.done_res)

  // Only one request is in flight against the table
  `BMRU_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Every taken request is followed by a valid result on the output
  `BMRU_ASSERT(a_result_shows, clk_i, rst_ni, in_valid_i && in_ready_o |-> ##2 out_valid_o)

endmodule

bind binary_multiset_rank_unrank_top bmru_checker u_bmru_checker (.*);

`default_nettype wire
